### hdl/dadd_pkg.sv
`timescale 1ns / 1ps

package dadd_pkg;

	// calendar bounds
	localparam logic [13:0] YEAR_MIN = 14'd1;
	localparam logic [13:0] YEAR_MAX = 14'd9999;
	localparam logic [3:0]  MONTH_JAN = 4'd1;
	localparam logic [3:0]  MONTH_FEB = 4'd2;
	localparam logic [3:0]  MONTH_DEC = 4'd12;
	localparam logic [4:0]  DAY_FIRST = 5'd1;
	localparam logic [4:0]  DAY_LAST_DEC = 5'd31;

	// year split into century and year of century, y = 100 * c + r
	localparam logic [6:0]  YOC_LAST = 7'd99;
	localparam logic [13:0] CENTURY_YEARS = 14'd100;
	// floor(y / 100) = (y * 5243) >> 19 for every year up to 9999
	localparam logic [25:0] CENT_RECIP = 26'd5243;
	localparam int          CENT_SHIFT = 19;

	// one date as carried between the sequencer and the step unit
	typedef struct packed {
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [6:0]  c;
		logic [6:0]  r;
	} dadd_date_t;

	// gregorian rule from the century split
	function automatic logic leap_of(input logic [6:0] c, input logic [6:0] r);
		logic lp;
		if (r == 7'd0) begin
			lp = (c[1:0] == 2'd0);
		end else begin
			lp = (r[1:0] == 2'd0);
		end
		return lp;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default:                 len = 5'd31;
		endcase
		return len;
	endfunction

endpackage

### hdl/date_add_subtract_days.sv
`timescale 1ns / 1ps

// Gregorian date stepper: moves a date forward or backward by a day count.
// Input channel in_valid/in_ready carries day_in, month_in, year_in,
// day_count and backward; one result beat leaves on out_valid/out_ready
// with day_out, month_out, year_out, is_leap and range_error.
// Out-of-range start fields are silently clamped to a legal date.
// Only the low COUNT_BITS bits of day_count are used (at most 16).
// The block works on one item at a time: setup multiplies the year by a
// reciprocal, splits it into century and year of century and clamps the day,
// then the step unit advances one day per cycle until the count is used up,
// then the result is loaded. Stepping stops early at 0001-01-01 or 9999-12-31
// with range_error set.
// in_ready is high only while the sequencer is idle; a finished result sits
// in the output register, and the next item is accepted while it waits.
// If the receiver still stalls when the next item is done, that item holds
// in the sequencer until the output register frees.
// Reset clears the sequencer and drops any pending result.
module date_add_subtract_days #(
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  day_in,
	input  logic [3:0]  month_in,
	input  logic [13:0] year_in,
	input  logic [15:0] day_count,
	input  logic        backward,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  day_out,
	output logic [3:0]  month_out,
	output logic [13:0] year_out,
	output logic        is_leap,
	output logic        range_error
);
	import dadd_pkg::*;

	localparam int NB = (COUNT_BITS < 16) ? COUNT_BITS : 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SPLIT,
		ST_CENT,
		ST_FIX,
		ST_STEP,
		ST_DONE
	} state_t;

	state_t      state_q;
	dadd_date_t  date_q;
	dadd_date_t  date_nxt;
	logic        bound_hit;
	logic        back_q;
	logic        err_q;
	logic [NB-1:0] count_q;
	logic [25:0] prod_q;
	logic [6:0]  cent;
	logic [13:0] yoc_full;
	logic [4:0]  fix_len;
	logic        out_valid_q;
	logic [4:0]  day_out_q;
	logic [3:0]  month_out_q;
	logic [13:0] year_out_q;
	logic        is_leap_q;
	logic        range_error_q;
	logic [3:0]  m_clamp;
	logic [13:0] y_clamp;
	logic [4:0]  d_clamp;

	// input clamps that need no month length
	always_comb begin
		m_clamp = month_in;
		if (month_in < MONTH_JAN) begin
			m_clamp = MONTH_JAN;
		end else if (month_in > MONTH_DEC) begin
			m_clamp = MONTH_DEC;
		end
		y_clamp = year_in;
		if (year_in < YEAR_MIN) begin
			y_clamp = YEAR_MIN;
		end else if (year_in > YEAR_MAX) begin
			y_clamp = YEAR_MAX;
		end
		d_clamp = (day_in < DAY_FIRST) ? DAY_FIRST : day_in;
	end

	// century split from the registered product
	assign cent     = prod_q[CENT_SHIFT+6:CENT_SHIFT];
	assign yoc_full = date_q.y - 14'(CENTURY_YEARS * 14'(cent));
	assign fix_len  = month_len(date_q.m, leap_of(date_q.c, date_q.r));

	dadd_step u_step (
		.cur      (date_q),
		.backward (back_q),
		.nxt      (date_nxt),
		.at_bound (bound_hit)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			date_q        <= '0;
			back_q        <= 1'b0;
			err_q         <= 1'b0;
			count_q       <= '0;
			prod_q        <= '0;
			day_out_q     <= '0;
			month_out_q   <= '0;
			year_out_q    <= '0;
			is_leap_q     <= 1'b0;
			range_error_q <= 1'b0;
		end else begin
			// a waiting result leaves; the done state reloads it on its own
			if (out_valid_q && out_ready && state_q != ST_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						date_q.d <= d_clamp;
						date_q.m <= m_clamp;
						date_q.y <= y_clamp;
						back_q   <= backward;
						count_q  <= day_count[NB-1:0];
						err_q    <= 1'b0;
						state_q  <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					prod_q  <= 26'(date_q.y) * CENT_RECIP;
					state_q <= ST_CENT;
				end
				ST_CENT: begin
					date_q.c <= cent;
					date_q.r <= yoc_full[6:0];
					state_q  <= ST_FIX;
				end
				ST_FIX: begin
					if (date_q.d > fix_len) begin
						date_q.d <= fix_len;
					end
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (count_q == '0) begin
						state_q <= ST_DONE;
					end else if (bound_hit) begin
						err_q   <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						date_q  <= date_nxt;
						count_q <= count_q - NB'(1);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						day_out_q     <= date_q.d;
						month_out_q   <= date_q.m;
						year_out_q    <= date_q.y;
						is_leap_q     <= leap_of(date_q.c, date_q.r);
						range_error_q <= err_q;
						out_valid_q   <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign day_out     = day_out_q;
	assign month_out   = month_out_q;
	assign year_out    = year_out_q;
	assign is_leap     = is_leap_q;
	assign range_error = range_error_q;

`ifndef SYNTHESIS
	// century split stays consistent with the year while stepping
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |->
			(date_q.y == 14'(CENTURY_YEARS * 14'(date_q.c)) + 14'(date_q.r)))
		else $error("year split out of step with year");

	// a result beat always carries day, month and year within their ranges
	a_date: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (day_out >= DAY_FIRST && day_out <= DAY_LAST_DEC &&
			month_out >= MONTH_JAN && month_out <= MONTH_DEC &&
			year_out >= YEAR_MIN && year_out <= YEAR_MAX))
		else $error("result date out of range");

	// an accepted beat closes the input until the item is done
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input open while an item is in work");

	// the step unit never runs past the day length of the month
	a_day: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (date_q.d <= fix_len))
		else $error("day beyond month length");
`endif

endmodule

### hdl/dadd_step.sv
`timescale 1ns / 1ps

// one day forward or backward on the current date
module dadd_step (
	input  dadd_pkg::dadd_date_t cur,
	input  logic                 backward,
	output dadd_pkg::dadd_date_t nxt,
	output logic                 at_bound
);
	import dadd_pkg::*;

	logic       leap;
	logic [4:0] len_cur;
	logic [4:0] len_prev;
	logic [3:0] m_prev;

	assign leap     = leap_of(cur.c, cur.r);
	assign len_cur  = month_len(cur.m, leap);
	assign m_prev   = cur.m - 4'd1;
	assign len_prev = month_len(m_prev, leap);

	always_comb begin
		nxt      = cur;
		at_bound = 1'b0;
		if (!backward) begin
			// forward: day, then month, then year rollover
			if (cur.d < len_cur) begin
				nxt.d = cur.d + 5'd1;
			end else if (cur.m < MONTH_DEC) begin
				nxt.d = DAY_FIRST;
				nxt.m = cur.m + 4'd1;
			end else if (cur.y < YEAR_MAX) begin
				nxt.d = DAY_FIRST;
				nxt.m = MONTH_JAN;
				nxt.y = cur.y + 14'd1;
				if (cur.r == YOC_LAST) begin
					nxt.r = 7'd0;
					nxt.c = cur.c + 7'd1;
				end else begin
					nxt.r = cur.r + 7'd1;
				end
			end else begin
				at_bound = 1'b1;
			end
		end else begin
			// backward: day, then month, then year rollover
			if (cur.d > DAY_FIRST) begin
				nxt.d = cur.d - 5'd1;
			end else if (cur.m > MONTH_JAN) begin
				nxt.m = m_prev;
				nxt.d = len_prev;
			end else if (cur.y > YEAR_MIN) begin
				nxt.d = DAY_LAST_DEC;
				nxt.m = MONTH_DEC;
				nxt.y = cur.y - 14'd1;
				if (cur.r == 7'd0) begin
					nxt.r = YOC_LAST;
					nxt.c = cur.c - 7'd1;
				end else begin
					nxt.r = cur.r - 7'd1;
				end
			end else begin
				at_bound = 1'b1;
			end
		end
	end

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;

	import dadd_pkg::*;

	localparam int COUNT_BITS = 16;
	// longest quiet stretch: a full 16-bit count plus setup, stalls and gaps, taken several times
	localparam int QUIET_LIMIT = 300000;
	localparam int DRAIN_CYCLES = 20;
	localparam int RANDOM_ITEMS = 100;

	typedef struct packed {
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic        leap;
		logic        err;
	} date_result_t;

	typedef enum logic [1:0] {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_SLOW} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  day_in = '0;
	logic [3:0]  month_in = '0;
	logic [13:0] year_in = '0;
	logic [15:0] day_count = '0;
	logic        backward = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [13:0] year_out;
	logic        is_leap;
	logic        range_error;

	date_result_t pending_dates[$];
	int           fail_count = 0;
	int           burst_left = 0;
	int           quiet_cycles = 0;
	rx_mode_t     rx_mode = RX_ALWAYS;
	int           rx_phase = 0;
	logic [3:0]   rx_tick = '0;

	date_add_subtract_days #(
		.COUNT_BITS(COUNT_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.day_in(day_in),
		.month_in(month_in),
		.year_in(year_in),
		.day_count(day_count),
		.backward(backward),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.day_out(day_out),
		.month_out(month_out),
		.year_out(year_out),
		.is_leap(is_leap),
		.range_error(range_error)
	);

	// clock
	initial begin
		forever #1 clk = ~clk;
	end

	// gregorian calendar rules
	function automatic bit gregorian_leap(input int unsigned y);
		if (y % 4 != 0) return 1'b0;
		if (y % 100 != 0) return 1'b1;
		return (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
		if (m == MONTH_FEB) return gregorian_leap(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
		return 31;
	endfunction

	// clamp the start date, then walk it one day at a time, stopping at the calendar bounds
	function automatic date_result_t step_date(input logic [4:0] d_in, input logic [3:0] m_in,
			input logic [13:0] y_in, input logic [15:0] cnt, input logic back);
		int unsigned  d;
		int unsigned  m;
		int unsigned  y;
		int unsigned  n;
		bit           err;
		date_result_t res;
		d = 32'(d_in);
		m = 32'(m_in);
		y = 32'(y_in);
		n = 32'(cnt) & 32'((33'd1 << COUNT_BITS) - 33'd1);
		err = 1'b0;
		if (m < MONTH_JAN) m = 32'(MONTH_JAN);
		if (m > MONTH_DEC) m = 32'(MONTH_DEC);
		if (y < YEAR_MIN) y = 32'(YEAR_MIN);
		if (y > YEAR_MAX) y = 32'(YEAR_MAX);
		if (d < DAY_FIRST) d = 32'(DAY_FIRST);
		if (d > days_in_month(m, y)) d = days_in_month(m, y);
		for (int unsigned i = 0; i < n && !err; i++) begin
			if (!back) begin
				if (d < days_in_month(m, y)) begin
					d++;
				end else if (m < MONTH_DEC) begin
					d = 32'(DAY_FIRST);
					m++;
				end else if (y < YEAR_MAX) begin
					d = 32'(DAY_FIRST);
					m = 32'(MONTH_JAN);
					y++;
				end else begin
					err = 1'b1;
				end
			end else begin
				if (d > DAY_FIRST) begin
					d--;
				end else if (m > MONTH_JAN) begin
					m--;
					d = days_in_month(m, y);
				end else if (y > YEAR_MIN) begin
					y--;
					m = 32'(MONTH_DEC);
					d = 32'(DAY_LAST_DEC);
				end else begin
					err = 1'b1;
				end
			end
		end
		res.d = 5'(d);
		res.m = 4'(m);
		res.y = 14'(y);
		res.leap = gregorian_leap(y);
		res.err = err;
		return res;
	endfunction

	// send one date beat, with bursts and random gaps on the input side
	task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
			input logic [15:0] cnt, input logic back);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 5);
		end
		burst_left--;
		in_valid <= 1'b1;
		day_in <= d;
		month_in <= m;
		year_in <= y;
		day_count <= cnt;
		backward <= back;
		do @(posedge clk); while (!in_ready);
		pending_dates.push_back(step_date(d, m, y, cnt, back));
	endtask

	// silent correction of out-of-range start fields
	task automatic test_clamping();
		send_date(5'd0, 4'd5, 14'd2023, 16'd0, 1'b0);
		send_date(5'd31, 4'd2, 14'd2023, 16'd0, 1'b0);
		send_date(5'd30, 4'd2, 14'd2024, 16'd0, 1'b0);
		send_date(5'd31, 4'd4, 14'd2021, 16'd0, 1'b1);
		send_date(5'd15, 4'd0, 14'd2020, 16'd0, 1'b0);
		send_date(5'd15, 4'd15, 14'd2020, 16'd0, 1'b0);
		send_date(5'd10, 4'd13, 14'd1999, 16'd1, 1'b0);
		send_date(5'd1, 4'd1, 14'd0, 16'd0, 1'b0);
		send_date(5'd20, 4'd6, 14'd16383, 16'd0, 1'b0);
		send_date(5'd31, 4'd12, 14'd10000, 16'd1, 1'b0);
	endtask

	// month and year rollover, including leap and non-leap centuries
	task automatic test_rollover();
		send_date(5'd28, 4'd2, 14'd2024, 16'd1, 1'b0);
		send_date(5'd28, 4'd2, 14'd1900, 16'd1, 1'b0);
		send_date(5'd28, 4'd2, 14'd2000, 16'd2, 1'b0);
		send_date(5'd28, 4'd2, 14'd2100, 16'd1, 1'b0);
		send_date(5'd31, 4'd12, 14'd1999, 16'd1, 1'b0);
		send_date(5'd1, 4'd1, 14'd2000, 16'd1, 1'b1);
		send_date(5'd1, 4'd3, 14'd2023, 16'd1, 1'b1);
		send_date(5'd1, 4'd3, 14'd2400, 16'd1, 1'b1);
	endtask

	// stepping stops at 0001-01-01 and 9999-12-31
	task automatic test_bounds();
		send_date(5'd31, 4'd12, 14'd9999, 16'd1, 1'b0);
		send_date(5'd25, 4'd12, 14'd9999, 16'd10, 1'b0);
		send_date(5'd1, 4'd1, 14'd1, 16'd1, 1'b1);
		send_date(5'd3, 4'd1, 14'd1, 16'd10, 1'b1);
	endtask

	// full-width day counts
	task automatic test_long_counts();
		send_date(5'd1, 4'd1, 14'd2000, 16'hffff, 1'b0);
		send_date(5'd31, 4'd15, 14'd16383, 16'hffff, 1'b1);
	endtask

	// mostly legal dates, some near the bounds, some raw noise
	task automatic test_random();
		int          kind;
		int          pick;
		logic [4:0]  d;
		logic [3:0]  m;
		logic [13:0] y;
		logic [15:0] cnt;
		logic        back;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == RANDOM_ITEMS / 2) begin
				// hold off until the block has drained
				in_valid <= 1'b0;
				while (pending_dates.size() != 0) @(posedge clk);
			end
			kind = $urandom_range(0, 99);
			pick = $urandom_range(0, 99);
			back = 1'($urandom_range(0, 1));
			if (pick < 2) cnt = 16'($urandom_range(0, 65535));
			else if (pick < 15) cnt = 16'($urandom_range(0, 4000));
			else cnt = 16'($urandom_range(0, 600));
			if (kind < 70) begin
				m = 4'($urandom_range(1, 12));
				y = 14'($urandom_range(1, 9999));
				d = 5'($urandom_range(1, days_in_month(m, y)));
			end else if (kind < 85) begin
				m = 4'($urandom_range(1, 12));
				if ($urandom_range(0, 1)) begin
					y = 14'($urandom_range(1, 2));
					back = ($urandom_range(0, 4) != 0);
				end else begin
					y = 14'($urandom_range(9998, 9999));
					back = ($urandom_range(0, 4) == 0);
				end
				d = 5'($urandom_range(1, days_in_month(m, y)));
				if (pick >= 2) cnt = 16'($urandom_range(0, 1200));
			end else begin
				d = 5'($urandom_range(0, 31));
				m = 4'($urandom_range(0, 15));
				y = 14'($urandom_range(0, 16383));
			end
			send_date(d, m, y, cnt, back);
		end
	endtask

	// receiver stall pattern, with a new random mode whenever the phase counter runs out
	always @(posedge clk) begin
		if (rx_phase == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_phase <= $urandom_range(16, 96);
		end else begin
			rx_phase <= rx_phase - 1;
		end
		rx_tick <= rx_tick + 4'd1;
		case (rx_mode)
			RX_ALWAYS: out_ready <= 1'b1;
			RX_RANDOM: out_ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
			default:   out_ready <= rx_tick[3];
		endcase
	end

	// compare each result beat with the oldest expected date
	always @(posedge clk) begin
		date_result_t want;
		if (out_valid && out_ready) begin
			if (pending_dates.size() == 0) begin
				if (fail_count < 10)
					$display("unexpected result beat %0d-%0d-%0d", year_out, month_out, day_out);
				fail_count++;
			end else begin
				want = pending_dates.pop_front();
				if (day_out !== want.d || month_out !== want.m || year_out !== want.y ||
						is_leap !== want.leap || range_error !== want.err) begin
					if (fail_count < 10)
						$display("mismatch: expected %0d-%0d-%0d leap %0d err %0d, got %0d-%0d-%0d leap %0d err %0d",
							want.y, want.m, want.d, want.leap, want.err,
							year_out, month_out, day_out, is_leap, range_error);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// test sequence
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_clamping();
		test_rollover();
		test_bounds();
		test_long_counts();
		test_random();
		in_valid <= 1'b0;
		while (pending_dates.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending_dates.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
